[rtl/ltc_pkg.sv]
// ----------------------------------------------------------------------------
// Tone-curve evaluator package
// Shared types, codes and constants for the Lagrange tone-curve evaluator.
// ----------------------------------------------------------------------------
package ltc_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_RANGE = 2'd2
    } t_ltc_status;

    // Register decode on the word-select bit of paddr.
    localparam logic       ADDR_POINT_COUNT = 1'b0;
    localparam logic [3:0] POINT_COUNT_RST  = 4'd2;

    // Upper clamp of the Q8.8 result (255.0).
    localparam logic [15:0] CLAMP_HIGH = 16'hFF00;

    // Input word.
    typedef struct packed {
        logic       req_type;
        logic [2:0] point_index;
        logic [7:0] point_x;
        logic [7:0] point_y;
        logic [7:0] query_x;
    } t_ltc_in;

    // Output word.
    typedef struct packed {
        logic [15:0] curve_value;
        logic [1:0]  status;
    } t_ltc_out;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CAPTURE,
        OP_TERM_INIT,
        OP_K_LOAD,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ACCUM
    } t_ltc_op;

    typedef struct packed {
        t_ltc_op op;
        logic    mem_we;
    } t_ltc_cmd;

    typedef struct packed {
        logic x_equal;
        logic y_zero;
        logic num_zero;
    } t_ltc_stat;

    typedef struct packed {
        logic        valid;
        t_ltc_status status;
    } t_ltc_done;

endpackage

[rtl/ltc_dpath.sv]
// ----------------------------------------------------------------------------
// Tone-curve evaluator datapath
// Point store, serial multipliers, restoring divider and term accumulator.
// ----------------------------------------------------------------------------
module ltc_dpath #(
    parameter int MAX_POINTS = 8,
    parameter int IDX_W      = 3
) (
    input  logic                i_clk,
    input  ltc_pkg::t_ltc_cmd   i_cmd,
    input  ltc_pkg::t_ltc_in    i_in,
    input  logic [IDX_W-1:0]    i_rd_a,
    input  logic [IDX_W-1:0]    i_rd_b,
    output ltc_pkg::t_ltc_stat  o_stat,
    output logic [15:0]         o_value
);
    import ltc_pkg::*;

    localparam int DEN_W = 8 * (MAX_POINTS - 1);
    localparam int NUM_W = 16 + DEN_W;
    localparam int SUM_W = NUM_W + 5;

    logic [7:0]        r_xmem [MAX_POINTS];
    logic [7:0]        r_ymem [MAX_POINTS];
    logic [7:0]        r_xa, r_ya, r_xb;
    logic [7:0]        r_qx, r_xj, r_mq, r_md;
    logic [NUM_W-1:0]  r_num, r_mop;
    logic [DEN_W-1:0]  r_den, r_dop, r_rem;
    logic              r_neg;
    logic [SUM_W-1:0]  r_sum;

    logic [7:0]        dq, dd;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_diff;
    logic              ge;
    logic [SUM_W-1:0]  q_ext;

    // Point store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_xmem[IDX_W'(i_in.point_index)] <= i_in.point_x;
            r_ymem[IDX_W'(i_in.point_index)] <= i_in.point_y;
        end
        r_xa <= r_xmem[i_rd_a];
        r_ya <= r_ymem[i_rd_a];
        r_xb <= r_xmem[i_rd_b];
    end

    // Distances from the other point's x, and one restoring division trial.
    always_comb begin
        dq         = (r_qx >= r_xb) ? (r_qx - r_xb) : (r_xb - r_qx);
        dd         = (r_xj >= r_xb) ? (r_xj - r_xb) : (r_xb - r_xj);
        trial      = {r_rem, r_num[NUM_W-1]};
        trial_diff = trial - {1'b0, r_den};
        ge         = (trial >= {1'b0, r_den});
        q_ext      = {{(SUM_W-NUM_W){1'b0}}, r_num};
    end

    // Arithmetic registers, one operation per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_qx  <= i_in.query_x;
                r_sum <= '0;
            end
            OP_TERM_INIT: begin
                r_num <= NUM_W'({r_ya, 8'h00});
                r_den <= DEN_W'(1);
                r_neg <= 1'b0;
                r_xj  <= r_xa;
            end
            OP_K_LOAD: begin
                r_mq  <= dq;
                r_md  <= dd;
                r_mop <= r_num;
                r_dop <= r_den;
                r_num <= '0;
                r_den <= '0;
                r_neg <= r_neg ^ (r_qx < r_xb) ^ (r_xj < r_xb);
            end
            OP_MUL_STEP: begin
                if (r_mq[0]) begin
                    r_num <= r_num + r_mop;
                end
                if (r_md[0]) begin
                    r_den <= r_den + r_dop;
                end
                r_mop <= {r_mop[NUM_W-2:0], 1'b0};
                r_dop <= {r_dop[DEN_W-2:0], 1'b0};
                r_mq  <= {1'b0, r_mq[7:1]};
                r_md  <= {1'b0, r_md[7:1]};
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
            end
            OP_ACCUM: begin
                r_sum <= r_neg ? (r_sum - q_ext) : (r_sum + q_ext);
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller and the clamped result.
    always_comb begin
        o_stat.x_equal  = (r_xa == r_xb);
        o_stat.y_zero   = (r_ya == 8'h00);
        o_stat.num_zero = (r_num == '0);
        if (r_sum[SUM_W-1]) begin
            o_value = 16'h0000;
        end else if (r_sum > SUM_W'(CLAMP_HIGH)) begin
            o_value = CLAMP_HIGH;
        end else begin
            o_value = r_sum[15:0];
        end
    end

endmodule

[rtl/ltc_ctrl.sv]
// ----------------------------------------------------------------------------
// Tone-curve evaluator controller
// Sequences the repeated-x scan, the product loops and the divider per term.
// ----------------------------------------------------------------------------
module ltc_ctrl #(
    parameter int MAX_POINTS = 8,
    parameter int IDX_W      = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ltc_pkg::t_ltc_in   i_in,
    input  logic [3:0]         i_point_count,
    input  logic               i_out_free,
    input  ltc_pkg::t_ltc_stat i_stat,
    output logic               o_busy,
    output ltc_pkg::t_ltc_cmd  o_cmd,
    output logic [IDX_W-1:0]   o_rd_a,
    output logic [IDX_W-1:0]   o_rd_b,
    output ltc_pkg::t_ltc_done o_done
);
    import ltc_pkg::*;

    localparam int DEN_W = 8 * (MAX_POINTS - 1);
    localparam int NUM_W = 16 + DEN_W;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DC_W  = $clog2(NUM_W);

    typedef enum logic [3:0] {
        S_IDLE, S_DUP_RD, S_DUP_CMP, S_TERM_RD, S_TERM_INIT, S_K_RD,
        S_K_LD, S_MUL, S_DIV_CHK, S_DIV, S_ACC, S_FINISH
    } t_state;

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_j, n_j, r_k, n_k, r_cnt, n_cnt;
    logic [2:0]  r_bit, n_bit;
    logic [DC_W-1:0] r_dcnt, n_dcnt;
    t_ltc_status r_status, n_status;
    logic        accept, idx_ok, j_last;

    always_comb begin
        accept = i_in_valid && (r_state == S_IDLE);
        idx_ok = (32'(i_in.point_index) < MAX_POINTS);
        j_last = ((r_j + CNT_W'(1)) == r_cnt);
        o_busy = (r_state != S_IDLE);
        o_rd_a = r_j[IDX_W-1:0];
        o_rd_b = r_k[IDX_W-1:0];
        o_done.valid  = (r_state == S_FINISH) && i_out_free;
        o_done.status = r_status;
    end

    // Datapath command for each state.
    always_comb begin
        o_cmd.mem_we = accept && (i_in.req_type == REQ_LOAD) && idx_ok;
        unique case (r_state)
            S_IDLE:      o_cmd.op = accept ? OP_CAPTURE : OP_IDLE;
            S_TERM_INIT: o_cmd.op = OP_TERM_INIT;
            S_K_LD:      o_cmd.op = OP_K_LOAD;
            S_MUL:       o_cmd.op = OP_MUL_STEP;
            S_DIV_CHK:   o_cmd.op = OP_DIV_INIT;
            S_DIV:       o_cmd.op = OP_DIV_STEP;
            S_ACC:       o_cmd.op = OP_ACCUM;
            default:     o_cmd.op = OP_IDLE;
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_bit    = r_bit;
        n_dcnt   = r_dcnt;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_j      = '0;
                    n_k      = CNT_W'(1);
                    n_cnt    = CNT_W'(i_point_count);
                    if (i_in.req_type == REQ_LOAD) begin
                        n_status = idx_ok ? ST_OK : ST_RANGE;
                        n_state  = S_FINISH;
                    end else if (32'(i_point_count) > MAX_POINTS) begin
                        n_status = ST_RANGE;
                        n_state  = S_FINISH;
                    end else if (i_point_count == 4'd0) begin
                        n_state = S_FINISH;
                    end else if (i_point_count == 4'd1) begin
                        n_state = S_TERM_RD;
                    end else begin
                        n_state = S_DUP_RD;
                    end
                end
            end
            S_DUP_RD: n_state = S_DUP_CMP;
            S_DUP_CMP: begin
                if (i_stat.x_equal) begin
                    n_status = ST_DUP;
                    n_state  = S_FINISH;
                end else if ((r_k + CNT_W'(1)) == r_cnt) begin
                    if ((r_j + CNT_W'(2)) == r_cnt) begin
                        n_j     = '0;
                        n_state = S_TERM_RD;
                    end else begin
                        n_j     = r_j + CNT_W'(1);
                        n_k     = r_j + CNT_W'(2);
                        n_state = S_DUP_RD;
                    end
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_DUP_RD;
                end
            end
            S_TERM_RD: n_state = S_TERM_INIT;
            S_TERM_INIT: begin
                n_k = '0;
                if (i_stat.y_zero) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = j_last ? S_FINISH : S_TERM_RD;
                end else begin
                    n_state = S_K_RD;
                end
            end
            S_K_RD: begin
                if (r_k == r_cnt) begin
                    n_state = S_DIV_CHK;
                end else if (r_k == r_j) begin
                    n_k = r_k + CNT_W'(1);
                end else begin
                    n_state = S_K_LD;
                end
            end
            S_K_LD: begin
                n_bit   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_K_RD;
                end
            end
            S_DIV_CHK: begin
                n_dcnt = '0;
                if (i_stat.num_zero) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = j_last ? S_FINISH : S_TERM_RD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_dcnt = r_dcnt + DC_W'(1);
                if (r_dcnt == DC_W'(NUM_W - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_j     = r_j + CNT_W'(1);
                n_state = j_last ? S_FINISH : S_TERM_RD;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_bit    <= '0;
            r_dcnt   <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_bit    <= n_bit;
            r_dcnt   <= n_dcnt;
            r_status <= n_status;
        end
    end

    // A repeated x always ends the scan with the repeated-x status.
    a_dup_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUP_CMP) && i_stat.x_equal |=>
            (r_state == S_FINISH) && (r_status == ST_DUP))
        else $error("repeated x did not end the evaluation");

    // The multiply loop always runs eight steps before the next point.
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && (r_bit != 3'd7) |=> (r_state == S_MUL))
        else $error("multiply loop left early");

    // Term indices stay inside the used points while the terms run.
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM_INIT) || (r_state == S_K_RD) |-> (r_j < r_cnt))
        else $error("term index beyond point count");

endmodule

[rtl/lagrange_tone_curve_eval.sv]
// ----------------------------------------------------------------------------
// Lagrange tone-curve evaluator, top level
// Control-point store with Lagrange interpolation, Q8.8 result clamped.
// ----------------------------------------------------------------------------
// Usage: words enter on i_in_valid / o_in_stall / i_in_data and results leave
// on o_out_valid / i_out_stall / o_out_data, one result word per input word.
// A load word writes one control point. An evaluate word first scans the
// first point_count points for a repeated x, pair by pair, then builds each
// term with a serial shift-add multiplier and a restoring divider (one
// quotient bit per cycle over a 16 + 8*(MAX_POINTS-1) bit numerator).
// Terms with a zero y skip the work. One word is worked on at a time;
// o_in_stall is high while it is in hand. The result waits in an output
// register, so the next word is taken while it is stalled; a finished
// result waits for that register to drain. Reset clears the control state
// and sets point_count to two; the point store is not cleared and must be
// loaded before it is evaluated. point_count is written over the APB-style
// port; the user must do so only while the block idles, as the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module lagrange_tone_curve_eval #(
    parameter int MAX_POINTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ltc_pkg::t_ltc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ltc_pkg::t_ltc_out o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ltc_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [3:0]       r_point_count;
    logic             r_out_valid;
    t_ltc_out         r_out_data;
    logic             out_free, busy, cfg_wr;
    t_ltc_cmd         cmd;
    t_ltc_stat        stat;
    t_ltc_done        done;
    logic [IDX_W-1:0] rd_a, rd_b;
    logic [15:0]      value;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_POINT_COUNT) ? {28'h0, r_point_count} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
        end else if (cfg_wr && (paddr[2] == ADDR_POINT_COUNT)) begin
            r_point_count <= pwdata[3:0];
        end
    end

    ltc_ctrl #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in          (i_in_data),
        .i_point_count (r_point_count),
        .i_out_free    (out_free),
        .i_stat        (stat),
        .o_busy        (busy),
        .o_cmd         (cmd),
        .o_rd_a        (rd_a),
        .o_rd_b        (rd_b),
        .o_done        (done)
    );

    ltc_dpath #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_dpath (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_stat  (stat),
        .o_value (value)
    );

    assign o_in_stall = busy;

    // Output register: filled when a result finishes, drained by the receiver.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done.valid) begin
            r_out_data.status      <= done.status;
            r_out_data.curve_value <= (done.status == ST_OK) ? value : 16'h0000;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A finished result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.valid |-> out_free)
        else $error("result overwrote a waiting word");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.curve_value == 16'h0000))
        else $error("error result with nonzero value");

    // An accepted word always holds off the next one: o_in_stall rises in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken without a busy cycle");

    // A register write lands in point_count.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && (paddr[2] == ADDR_POINT_COUNT) |=> (r_point_count == $past(pwdata[3:0])))
        else $error("point_count write lost");

endmodule

[tb/sv/lagrange_tone_curve_eval_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lagrange tone-curve evaluator testbench
// Loads control points, sets the point count over the register port and
// evaluates the curve. Every result word is checked against an in-bench
// predictor that forms each Lagrange term exactly in wide integers. Both
// handshake sides idle at random.
// ----------------------------------------------------------------------------
module lagrange_tone_curve_eval_tb;
    import ltc_pkg::*;

    localparam int NUM_SLOTS  = 8;
    localparam int IDLE_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_ltc_in           i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_ltc_out          o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state: the point store and the count in use.
    logic [7:0] pred_x [NUM_SLOTS];
    logic [7:0] pred_y [NUM_SLOTS];
    logic [3:0] pred_count;

    t_ltc_out curve_expect_q[$];
    bit       failed;
    bit       send_bursty;
    bit       drain_bursty;
    int       drain_hold;
    int       idle_cycles;

    lagrange_tone_curve_eval u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Interpolated value through the first pred_count points at qx.
    function automatic logic [15:0] curve_at(input logic [7:0] qx);
        logic [127:0]        num;
        logic [127:0]        den;
        logic [127:0]        quo;
        logic signed [131:0] acc;
        bit                  neg;
        acc = '0;
        for (int j = 0; j < pred_count; j++) begin
            if (pred_y[j] == 8'd0) continue;
            num = 128'(pred_y[j]) * 256;
            den = 128'd1;
            neg = 1'b0;
            for (int k = 0; k < pred_count; k++) begin
                if (k == j) continue;
                if (qx >= pred_x[k]) begin
                    num = num * 128'(qx - pred_x[k]);
                end else begin
                    num = num * 128'(pred_x[k] - qx);
                    neg = ~neg;
                end
                if (pred_x[j] >= pred_x[k]) begin
                    den = den * 128'(pred_x[j] - pred_x[k]);
                end else begin
                    den = den * 128'(pred_x[k] - pred_x[j]);
                    neg = ~neg;
                end
            end
            if (num == '0) continue;
            // Magnitude division truncates toward zero once the sign is applied.
            quo = num / den;
            if (neg) begin
                acc = acc - $signed({4'b0, quo});
            end else begin
                acc = acc + $signed({4'b0, quo});
            end
        end
        if (acc < 0) return 16'd0;
        if (acc > 132'sd65280) return CLAMP_HIGH;
        return acc[15:0];
    endfunction

    // Applies one accepted word to the predictor and returns its answer.
    function automatic t_ltc_out curve_predict(input t_ltc_in w);
        t_ltc_out r;
        bit       dup;
        r = '0;
        r.status = ST_OK;
        if (w.req_type == REQ_LOAD) begin
            if (w.point_index < NUM_SLOTS) begin
                pred_x[w.point_index] = w.point_x;
                pred_y[w.point_index] = w.point_y;
            end else begin
                r.status = ST_RANGE;
            end
        end else if (pred_count > NUM_SLOTS) begin
            r.status = ST_RANGE;
        end else begin
            dup = 1'b0;
            for (int j = 0; j < pred_count; j++)
                for (int k = j + 1; k < pred_count; k++)
                    if (pred_x[j] == pred_x[k]) dup = 1'b1;
            if (dup) r.status = ST_DUP;
            else r.curve_value = curve_at(w.query_x);
        end
        return r;
    endfunction

    // Sends one word, waits for acceptance, then idles for a random gap.
    task automatic send_word(input t_ltc_in w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        curve_expect_q.push_back(curve_predict(w));
        gap = send_bursty ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(input logic [2:0] idx, input logic [7:0] x, input logic [7:0] y);
        t_ltc_in w;
        w.req_type    = REQ_LOAD;
        w.point_index = idx;
        w.point_x     = x;
        w.point_y     = y;
        w.query_x     = 8'($urandom);
        send_word(w);
    endtask

    task automatic send_eval(input logic [7:0] qx);
        t_ltc_in w;
        w.req_type    = REQ_EVAL;
        w.point_index = 3'($urandom);
        w.point_x     = 8'($urandom);
        w.point_y     = 8'($urandom);
        w.query_x     = qx;
        send_word(w);
    endtask

    // Waits until every expected word has arrived, plus a short margin.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (curve_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write: setup phase, access phase, then idle.
    task automatic write_point_count(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ADDR_POINT_COUNT, 2'b0};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pred_count = value;
        @(posedge i_clk);
    endtask

    // Register read, compared with the predictor's copy.
    task automatic check_point_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {ADDR_POINT_COUNT, 2'b0};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[3:0] !== pred_count) begin
            $display("%0t point_count read: expected %0d actual %0d",
                     $realtime, pred_count, prdata[3:0]);
            failed = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_ltc_out exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (curve_expect_q.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h",
                         $realtime, o_out_data);
                failed = 1'b1;
            end else begin
                exp_w = curve_expect_q.pop_front();
                if (o_out_data.curve_value !== exp_w.curve_value) begin
                    $display("%0t curve_value: expected %h actual %h",
                             $realtime, exp_w.curve_value, o_out_data.curve_value);
                    failed = 1'b1;
                end
                if (o_out_data.status !== exp_w.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $realtime, exp_w.status, o_out_data.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver stall: a fresh hold drawn after each result word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drain_hold  <= 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            drain_hold  <= drain_bursty ? 0 : $urandom_range(0, 17);
            i_out_stall <= drain_bursty ? 1'b0 : ($urandom_range(0, 1) == 1);
        end else if (drain_hold > 0) begin
            drain_hold  <= drain_hold - 1;
            i_out_stall <= (drain_hold > 1);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Fills every slot, then covers extremes, clamping and repeated x.
    task automatic test_directed();
        write_point_count(4'd2);
        send_load(3'd0, 8'd0, 8'd0);
        send_load(3'd1, 8'd255, 8'd255);
        for (int i = 2; i < NUM_SLOTS; i++)
            send_load(3'(i), 8'(i * 30), 8'(255 - i * 20));
        send_eval(8'd0);
        send_eval(8'd255);
        send_eval(8'd128);
        wait_drained();
        // Steep line that overshoots above and below the range.
        write_point_count(4'd2);
        send_load(3'd0, 8'd100, 8'd0);
        send_load(3'd1, 8'd101, 8'd255);
        send_eval(8'd0);
        send_eval(8'd255);
        // Repeated x among the used points.
        send_load(3'd1, 8'd100, 8'd7);
        send_eval(8'd50);
        wait_drained();
        // Single point, no points, and a count beyond the store.
        write_point_count(4'd1);
        send_eval(8'd9);
        wait_drained();
        write_point_count(4'd0);
        send_eval(8'd9);
        wait_drained();
        write_point_count(4'd15);
        send_eval(8'd9);
        wait_drained();
        check_point_count();
    endtask

    // Random loads and evaluations over a range of point counts.
    task automatic test_random();
        logic [3:0] counts [10] = '{4'd8, 4'd2, 4'd5, 4'd3, 4'd8, 4'd4,
                                    4'd7, 4'd9, 4'd6, 4'd1};
        for (int p = 0; p < 10; p++) begin
            write_point_count(counts[p]);
            check_point_count();
            send_bursty  = (p % 3 == 1);
            drain_bursty = (p % 4 == 2);
            for (int n = 0; n < 75; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_load(3'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    send_eval(8'($urandom));
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        failed       = 1'b0;
        send_bursty  = 1'b0;
        drain_bursty = 1'b0;
        pred_count   = POINT_COUNT_RST;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pred_x[i] = '0;
            pred_y[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_point_count();
        test_directed();
        test_random();
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
